FILE: rtl/tsa_pkg.sv
package tsa_pkg;

	localparam int MAX_VERTICES  = 1024;
	localparam int MAX_TRIANGLES = 2048;

	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int TIDX_W = $clog2(MAX_TRIANGLES);

	// fixed field widths of the item channels
	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 12;
	localparam int COORD_W  = 32;
	localparam int CORNER_W = 10;
	localparam int LINK_W   = 11;
	localparam int TOTAL_W  = 12;
	localparam int STATUS_W = 2;
	localparam int VCNT_W   = 11;
	localparam int TCNT_W   = 12;

	localparam logic [KIND_W-1:0] K_LDV = 3'd0;
	localparam logic [KIND_W-1:0] K_LDT = 3'd1;
	localparam logic [KIND_W-1:0] K_SET = 3'd2;
	localparam logic [KIND_W-1:0] K_ADD = 3'd3;
	localparam logic [KIND_W-1:0] K_RDT = 3'd4;
	localparam logic [KIND_W-1:0] K_RDV = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// microcode step address
	localparam int STEP_W = 5;

	// vertex ram ops
	localparam logic [1:0] V_NONE    = 2'd0;
	localparam logic [1:0] V_WR_ITEM = 2'd1;
	localparam logic [1:0] V_WR_NEW  = 2'd2;
	localparam logic [1:0] V_RD      = 2'd3;

	// corner ram ops
	localparam logic [2:0] C_NONE    = 3'd0;
	localparam logic [2:0] C_WR_ITEM = 3'd1;
	localparam logic [2:0] C_RD      = 3'd2;
	localparam logic [2:0] C_WR_T0   = 3'd3;
	localparam logic [2:0] C_WR_T1   = 3'd4;
	localparam logic [2:0] C_WR_T2   = 3'd5;

	// adjacency ram ops
	localparam logic [2:0] A_NONE    = 3'd0;
	localparam logic [2:0] A_WR_ITEM = 3'd1;
	localparam logic [2:0] A_RD      = 3'd2;
	localparam logic [2:0] A_WR_T0   = 3'd3;
	localparam logic [2:0] A_WR_T1   = 3'd4;
	localparam logic [2:0] A_WR_T2   = 3'd5;
	localparam logic [2:0] A_RD_LINK = 3'd6;
	localparam logic [2:0] A_WR_LINK = 3'd7;

	// count ops
	localparam logic [1:0] CNT_NONE  = 2'd0;
	localparam logic [1:0] CNT_LOAD  = 2'd1;
	localparam logic [1:0] CNT_SPLIT = 2'd2;

	// sequencing ops
	localparam logic [2:0] SQ_NEXT     = 3'd0;
	localparam logic [2:0] SQ_ACCEPT   = 3'd1;
	localparam logic [2:0] SQ_DISPATCH = 3'd2;
	localparam logic [2:0] SQ_JUMP     = 3'd3;
	localparam logic [2:0] SQ_FINISH   = 3'd4;

	// outer link chosen for a redirect
	localparam logic [1:0] L_AB = 2'd0;
	localparam logic [1:0] L_BC = 2'd1;
	localparam logic [1:0] L_CA = 2'd2;

	typedef struct packed {
		logic [1:0]        vop;
		logic [2:0]        cop;
		logic [2:0]        aop;
		logic [1:0]        lsel;
		logic [1:0]        cnt;
		logic              latch_on;
		logic [2:0]        sq;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic              accepted;
		logic [KIND_W-1:0] kind;
		logic              err;
	} dp_flags_t;

	typedef struct packed {
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} vertex_t;

	typedef struct packed {
		logic [CORNER_W-1:0] c;
		logic [CORNER_W-1:0] b;
		logic [CORNER_W-1:0] a;
	} corner_t;

	typedef struct packed {
		logic [LINK_W-1:0] ca;
		logic [LINK_W-1:0] bc;
		logic [LINK_W-1:0] ab;
	} link_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		vertex_t             vtx;
		corner_t             crn;
		link_t               lnk;
		logic [VCNT_W-1:0]   vert_total;
		logic [TCNT_W-1:0]   tri_now;
	} res_t;

endpackage

FILE: rtl/tsa_cmd_if.sv
interface tsa_cmd_if import tsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [INDEX_W-1:0]  index;
	logic [COORD_W-1:0]  coord_x;
	logic [COORD_W-1:0]  coord_y;
	logic [COORD_W-1:0]  coord_z;
	logic [CORNER_W-1:0] corner_a;
	logic [CORNER_W-1:0] corner_b;
	logic [CORNER_W-1:0] corner_c;
	logic [LINK_W-1:0]   link_ab;
	logic [LINK_W-1:0]   link_bc;
	logic [LINK_W-1:0]   link_ca;
	logic [TOTAL_W-1:0]  tri_total;

	modport source (
		output valid, kind, index, coord_x, coord_y, coord_z,
		output corner_a, corner_b, corner_c, link_ab, link_bc, link_ca, tri_total,
		input  ready
	);
	modport sink (
		input  valid, kind, index, coord_x, coord_y, coord_z,
		input  corner_a, corner_b, corner_c, link_ab, link_bc, link_ca, tri_total,
		output ready
	);
endinterface

FILE: rtl/tsa_rsp_if.sv
interface tsa_rsp_if import tsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COORD_W-1:0]  out_x;
	logic [COORD_W-1:0]  out_y;
	logic [COORD_W-1:0]  out_z;
	logic [CORNER_W-1:0] out_a;
	logic [CORNER_W-1:0] out_b;
	logic [CORNER_W-1:0] out_c;
	logic [LINK_W-1:0]   out_ab;
	logic [LINK_W-1:0]   out_bc;
	logic [LINK_W-1:0]   out_ca;
	logic [VCNT_W-1:0]   vert_total;
	logic [TCNT_W-1:0]   tri_now;

	modport source (
		output valid, status, out_x, out_y, out_z, out_a, out_b, out_c,
		output out_ab, out_bc, out_ca, vert_total, tri_now,
		input  ready
	);
	modport sink (
		input  valid, status, out_x, out_y, out_z, out_a, out_b, out_c,
		input  out_ab, out_bc, out_ca, vert_total, tri_now,
		output ready
	);
endinterface

FILE: rtl/tsa_ram.sv
module tsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: rtl/tsa_seq.sv
module tsa_seq import tsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_flags_t flags,
	input  logic      out_busy,
	output ctrl_t     ctrl,
	output logic      emit
);

	localparam logic [STEP_W-1:0] S_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] S_DEC  = 5'd1;
	localparam logic [STEP_W-1:0] S_LDV  = 5'd2;
	localparam logic [STEP_W-1:0] S_LDT  = 5'd3;
	localparam logic [STEP_W-1:0] S_SETC = 5'd4;
	localparam logic [STEP_W-1:0] S_RDT  = 5'd5;
	localparam logic [STEP_W-1:0] S_RDV  = 5'd6;
	localparam logic [STEP_W-1:0] S_AP0  = 5'd7;
	localparam logic [STEP_W-1:0] S_AP1  = 5'd8;
	localparam logic [STEP_W-1:0] S_AP2  = 5'd9;
	localparam logic [STEP_W-1:0] S_AP3  = 5'd10;
	localparam logic [STEP_W-1:0] S_R0   = 5'd11;
	localparam logic [STEP_W-1:0] S_W0   = 5'd12;
	localparam logic [STEP_W-1:0] S_R1   = 5'd13;
	localparam logic [STEP_W-1:0] S_W1   = 5'd14;
	localparam logic [STEP_W-1:0] S_R2   = 5'd15;
	localparam logic [STEP_W-1:0] S_W2   = 5'd16;
	localparam logic [STEP_W-1:0] S_FIN  = 5'd17;

	function automatic ctrl_t rom(input logic [STEP_W-1:0] s);
		ctrl_t c;
		c = '0;
		case (s)
			S_IDLE: c.sq = SQ_ACCEPT;
			S_DEC:  c.sq = SQ_DISPATCH;
			S_LDV: begin
				c.vop = V_WR_ITEM; c.sq = SQ_JUMP; c.target = S_FIN;
			end
			S_LDT: begin
				c.cop = C_WR_ITEM; c.aop = A_WR_ITEM; c.sq = SQ_JUMP; c.target = S_FIN;
			end
			S_SETC: begin
				c.cnt = CNT_LOAD; c.sq = SQ_JUMP; c.target = S_FIN;
			end
			S_RDT: begin
				c.cop = C_RD; c.aop = A_RD; c.sq = SQ_JUMP; c.target = S_FIN;
			end
			S_RDV: begin
				c.vop = V_RD; c.sq = SQ_JUMP; c.target = S_FIN;
			end
			S_AP0: begin
				c.vop = V_WR_NEW; c.cop = C_RD; c.aop = A_RD; c.sq = SQ_NEXT;
			end
			S_AP1: begin
				c.cop = C_WR_T0; c.aop = A_WR_T0; c.latch_on = 1'b1; c.sq = SQ_NEXT;
			end
			S_AP2: begin
				c.cop = C_WR_T1; c.aop = A_WR_T1; c.sq = SQ_NEXT;
			end
			S_AP3: begin
				c.cop = C_WR_T2; c.aop = A_WR_T2; c.cnt = CNT_SPLIT; c.sq = SQ_NEXT;
			end
			S_R0: begin
				c.aop = A_RD_LINK; c.lsel = L_AB; c.sq = SQ_NEXT;
			end
			S_W0: begin
				c.aop = A_WR_LINK; c.lsel = L_AB; c.sq = SQ_NEXT;
			end
			S_R1: begin
				c.aop = A_RD_LINK; c.lsel = L_BC; c.sq = SQ_NEXT;
			end
			S_W1: begin
				c.aop = A_WR_LINK; c.lsel = L_BC; c.sq = SQ_NEXT;
			end
			S_R2: begin
				c.aop = A_RD_LINK; c.lsel = L_CA; c.sq = SQ_NEXT;
			end
			S_W2: begin
				c.aop = A_WR_LINK; c.lsel = L_CA; c.sq = SQ_NEXT;
			end
			S_FIN: c.sq = SQ_FINISH;
			default: begin
				c.sq = SQ_JUMP; c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	logic [STEP_W-1:0] dispatch;

	assign ctrl = rom(step_q);

	always_comb begin
		dispatch = S_FIN;
		if (!flags.err) begin
			case (flags.kind)
				K_LDV:   dispatch = S_LDV;
				K_LDT:   dispatch = S_LDT;
				K_SET:   dispatch = S_SETC;
				K_ADD:   dispatch = S_AP0;
				K_RDT:   dispatch = S_RDT;
				K_RDV:   dispatch = S_RDV;
				default: dispatch = S_FIN;
			endcase
		end
	end

	always_comb begin
		emit      = 1'b0;
		step_next = step_q;
		case (ctrl.sq)
			SQ_NEXT:     step_next = step_q + STEP_W'(1);
			SQ_ACCEPT:   if (flags.accepted) step_next = step_q + STEP_W'(1);
			SQ_DISPATCH: step_next = dispatch;
			SQ_JUMP:     step_next = ctrl.target;
			SQ_FINISH: begin
				if (!out_busy) begin
					emit      = 1'b1;
					step_next = S_IDLE;
				end
			end
			default:     step_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

FILE: rtl/tsa_dp.sv
module tsa_dp import tsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tsa_cmd_if.sink    cmd,
	input  ctrl_t      ctrl,
	output dp_flags_t  flags,
	output res_t       res
);

	logic [KIND_W-1:0]   kind_q;
	logic [INDEX_W-1:0]  idx_q;
	vertex_t             vtx_q;
	corner_t             crn_q;
	link_t               lnk_q;
	logic [TOTAL_W-1:0]  tt_q;
	logic [STATUS_W-1:0] status_q;
	logic [VIDX_W-1:0]   p_q;
	logic [TIDX_W-1:0]   t1_q;
	link_t               on_q;
	logic [VCNT_W-1:0]   vcount_q;
	logic [TCNT_W-1:0]   tcount_q;

	logic [STATUS_W-1:0] status_c;
	logic                accepted;
	logic [TIDX_W-1:0]   t0;
	logic [TIDX_W-1:0]   t2;
	logic [LINK_W-1:0]   l0;
	logic [LINK_W-1:0]   l1;
	logic [LINK_W-1:0]   l2;
	logic [CORNER_W-1:0] pc;

	logic                v_en, v_we, c_en, c_we, a_en, a_we;
	logic [VIDX_W-1:0]   v_addr;
	logic [TIDX_W-1:0]   c_addr, a_addr;
	vertex_t             v_wdata, v_rdata;
	corner_t             c_wdata, c_rdata;
	link_t               a_wdata, a_rdata, redir;
	logic [LINK_W-1:0]   outer;
	logic [LINK_W-1:0]   to_link;

	assign cmd.ready = (ctrl.sq == SQ_ACCEPT);
	assign accepted  = cmd.valid && cmd.ready;

	always_ff @(posedge clk) begin
		if (accepted) begin
			kind_q  <= cmd.kind;
			idx_q   <= cmd.index;
			vtx_q   <= '{z: cmd.coord_z, y: cmd.coord_y, x: cmd.coord_x};
			crn_q   <= '{c: cmd.corner_c, b: cmd.corner_b, a: cmd.corner_a};
			lnk_q   <= '{ca: cmd.link_ca, bc: cmd.link_bc, ab: cmd.link_ab};
			tt_q    <= cmd.tri_total;
		end
		if (ctrl.sq == SQ_DISPATCH) begin
			status_q <= status_c;
			p_q      <= vcount_q[VIDX_W-1:0];
			t1_q     <= tcount_q[TIDX_W-1:0];
		end
		if (ctrl.latch_on) begin
			on_q <= a_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			tcount_q <= '0;
		end else begin
			case (ctrl.cnt)
				CNT_LOAD: begin
					vcount_q <= idx_q[VCNT_W-1:0];
					tcount_q <= tt_q[TCNT_W-1:0];
				end
				CNT_SPLIT: begin
					vcount_q <= vcount_q + VCNT_W'(1);
					tcount_q <= tcount_q + TCNT_W'(2);
				end
				default: ;
			endcase
		end
	end

	// range and capacity checks, taken while decoding
	always_comb begin
		status_c = ST_OK;
		case (kind_q)
			K_LDV, K_RDV: begin
				if (32'(idx_q) >= MAX_VERTICES) status_c = ST_RANGE;
			end
			K_LDT, K_RDT: begin
				if (32'(idx_q) >= MAX_TRIANGLES) status_c = ST_RANGE;
			end
			K_SET: begin
				if (32'(idx_q) > MAX_VERTICES || 32'(tt_q) > MAX_TRIANGLES)
					status_c = ST_RANGE;
			end
			K_ADD: begin
				if (32'(idx_q) >= 32'(tcount_q))
					status_c = ST_RANGE;
				else if (32'(vcount_q) >= MAX_VERTICES ||
						32'(tcount_q) + 32'd2 > MAX_TRIANGLES)
					status_c = ST_FULL;
			end
			default: status_c = ST_OK;
		endcase
	end

	assign flags = '{accepted: accepted, kind: kind_q, err: (status_c != ST_OK)};

	assign t0 = idx_q[TIDX_W-1:0];
	assign t2 = t1_q + TIDX_W'(1);
	assign l0 = LINK_W'(t0);
	assign l1 = LINK_W'(t1_q);
	assign l2 = LINK_W'(t2);
	assign pc = CORNER_W'(p_q);

	// vertex store
	assign v_en    = (ctrl.vop != V_NONE);
	assign v_we    = (ctrl.vop == V_WR_ITEM) || (ctrl.vop == V_WR_NEW);
	assign v_addr  = (ctrl.vop == V_WR_NEW) ? p_q : idx_q[VIDX_W-1:0];
	assign v_wdata = vtx_q;

	// corner store; old corners stay in the read register across the rewrites
	always_comb begin
		c_en    = (ctrl.cop != C_NONE);
		c_we    = (ctrl.cop != C_NONE) && (ctrl.cop != C_RD);
		c_addr  = t0;
		c_wdata = crn_q;
		case (ctrl.cop)
			C_WR_T0: c_wdata = '{c: pc, b: c_rdata.b, a: c_rdata.a};
			C_WR_T1: begin
				c_addr  = t1_q;
				c_wdata = '{c: pc, b: c_rdata.c, a: c_rdata.b};
			end
			C_WR_T2: begin
				c_addr  = t2;
				c_wdata = '{c: pc, b: c_rdata.a, a: c_rdata.c};
			end
			default: ;
		endcase
	end

	// outer neighbour and the new triangle that replaces the old slot in it
	always_comb begin
		case (ctrl.lsel)
			L_AB: begin outer = on_q.ab; to_link = l0; end
			L_BC: begin outer = on_q.bc; to_link = l1; end
			L_CA: begin outer = on_q.ca; to_link = l2; end
			default: begin outer = on_q.ab; to_link = l0; end
		endcase
	end

	// first matching link in the order ab, bc, ca is redirected
	always_comb begin
		redir = a_rdata;
		if (a_rdata.ab == l0)
			redir.ab = to_link;
		else if (a_rdata.bc == l0)
			redir.bc = to_link;
		else if (a_rdata.ca == l0)
			redir.ca = to_link;
	end

	always_comb begin
		a_en    = (ctrl.aop != A_NONE);
		a_we    = (ctrl.aop != A_NONE) && (ctrl.aop != A_RD) && (ctrl.aop != A_RD_LINK);
		a_addr  = t0;
		a_wdata = lnk_q;
		case (ctrl.aop)
			A_WR_T0: a_wdata = '{ca: l2, bc: l1, ab: a_rdata.ab};
			A_WR_T1: begin
				a_addr  = t1_q;
				a_wdata = '{ca: l0, bc: l2, ab: on_q.bc};
			end
			A_WR_T2: begin
				a_addr  = t2;
				a_wdata = '{ca: l1, bc: l0, ab: on_q.ca};
			end
			A_RD_LINK: a_addr = outer[TIDX_W-1:0];
			A_WR_LINK: begin
				a_addr  = outer[TIDX_W-1:0];
				a_wdata = redir;
				if (32'(outer) >= MAX_TRIANGLES) begin
					a_en = 1'b0;
					a_we = 1'b0;
				end
			end
			default: ;
		endcase
	end

	tsa_ram #(.WIDTH($bits(vertex_t)), .DEPTH(MAX_VERTICES)) u_vram (
		.clk   (clk),
		.en    (v_en),
		.we    (v_we),
		.addr  (v_addr),
		.wdata (v_wdata),
		.rdata (v_rdata)
	);

	tsa_ram #(.WIDTH($bits(corner_t)), .DEPTH(MAX_TRIANGLES)) u_cram (
		.clk   (clk),
		.en    (c_en),
		.we    (c_we),
		.addr  (c_addr),
		.wdata (c_wdata),
		.rdata (c_rdata)
	);

	tsa_ram #(.WIDTH($bits(link_t)), .DEPTH(MAX_TRIANGLES)) u_aram (
		.clk   (clk),
		.en    (a_en),
		.we    (a_we),
		.addr  (a_addr),
		.wdata (a_wdata),
		.rdata (a_rdata)
	);

	always_comb begin
		res            = '0;
		res.status     = status_q;
		res.vert_total = vcount_q;
		res.tri_now    = tcount_q;
		if (status_q == ST_OK && kind_q == K_RDV) begin
			res.vtx = v_rdata;
		end
		if (status_q == ST_OK && kind_q == K_RDT) begin
			res.crn = c_rdata;
			res.lnk = a_rdata;
		end
	end

endmodule

FILE: rtl/triangle_split_adjacency_update.sv
// Mesh store with a one-to-three triangle split. Each item on cmd loads a vertex, loads a
// triangle with its three neighbours, sets both counts, reads a triangle or a vertex back,
// or adds a point, and gives exactly one item on rsp with the status and the counts after
// it. One item is worked at a time by a small microcoded sequencer over single-port vertex,
// corner and neighbour rams. A rejected item goes straight to its result, and an add point
// takes the neighbour ram through the three rewritten triangles and then a read and a write
// for each outer neighbour in turn. A new item is accepted while the previous result still
// waits on rsp. The stores have no reset; reading a slot never written returns whatever the
// ram holds.
module triangle_split_adjacency_update import tsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tsa_cmd_if.sink  cmd,
	tsa_rsp_if.source rsp
);

	ctrl_t     ctrl;
	dp_flags_t flags;
	res_t      res;
	logic      emit;
	logic      out_busy;
	logic      rsp_valid_q;
	res_t      res_q;

	tsa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.out_busy (out_busy),
		.ctrl     (ctrl),
		.emit     (emit)
	);

	tsa_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctrl   (ctrl),
		.flags  (flags),
		.res    (res)
	);

	// result register; a new item may land as the held one is taken
	assign out_busy = rsp_valid_q && !rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = res_q.status;
	assign rsp.out_x      = res_q.vtx.x;
	assign rsp.out_y      = res_q.vtx.y;
	assign rsp.out_z      = res_q.vtx.z;
	assign rsp.out_a      = res_q.crn.a;
	assign rsp.out_b      = res_q.crn.b;
	assign rsp.out_c      = res_q.crn.c;
	assign rsp.out_ab     = res_q.lnk.ab;
	assign rsp.out_bc     = res_q.lnk.bc;
	assign rsp.out_ca     = res_q.lnk.ca;
	assign rsp.vert_total = res_q.vert_total;
	assign rsp.tri_now    = res_q.tri_now;

endmodule
